// File: rtl/core/mts_pkg.sv
// Shared types, codes and the melody note table of the tone sequencer.
`default_nettype none

package mts_pkg;

  // Item kinds carried in the mode field.
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  // Configuration register indexes.
  localparam int          CFG_IDX_W      = 1;
  localparam int          CFG_DATA_W     = 7;
  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_PCT   = 1'd1;

  // Register reset values and upper limits.
  localparam logic [4:0] RES_BITS_RESET = 5'd10;
  localparam logic [6:0] DUTY_PCT_RESET = 7'd50;
  localparam logic [4:0] RES_BITS_MAX   = 5'd16;
  localparam logic [6:0] DUTY_PCT_MAX   = 7'd100;

  // Floor division by 100 as a reciprocal multiply, exact below 2^23.
  localparam int          DUTY_PROD_W = 23;
  localparam logic [23:0] DUTY_RECIP  = 24'd10737419;
  localparam int          DUTY_SHIFT  = 30;

  // Widths used to address the note table.
  localparam int NOTE_IDX_W = 6;
  localparam int LEN_W      = 7;

  // One request: item kind and melody selection.
  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] direction;
  } mts_in_t;

  // One result: tone frequency and PWM duty.
  typedef struct packed {
    logic [15:0] tone_freq;
    logic [15:0] duty;
  } mts_out_t;

  // One table entry: frequency in hertz and duration in milliseconds.
  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] dur;
  } note_t;

  // Number of notes stored for each melody.
  function automatic logic [3:0] rom_len(input logic [1:0] m);
    logic [3:0] n;
    case (m)
      2'd0:    n = 4'd4;
      2'd1:    n = 4'd5;
      2'd2:    n = 4'd6;
      2'd3:    n = 4'd5;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // Note table; entries past a melody's end read as zero.
  function automatic note_t rom_note(input logic [1:0] m, input logic [NOTE_IDX_W-1:0] i);
    note_t t;
    t = '0;
    case (m)
      2'd0: begin
        case (i)
          6'd0:    t = '{16'd1200, 16'd120};
          6'd1:    t = '{16'd900,  16'd120};
          6'd2:    t = '{16'd700,  16'd160};
          6'd3:    t = '{16'd0,    16'd80};
          default: t = '0;
        endcase
      end
      2'd1: begin
        case (i)
          6'd0:    t = '{16'd784,  16'd120};
          6'd1:    t = '{16'd880,  16'd120};
          6'd2:    t = '{16'd988,  16'd140};
          6'd3:    t = '{16'd1047, 16'd220};
          6'd4:    t = '{16'd0,    16'd80};
          default: t = '0;
        endcase
      end
      2'd2: begin
        case (i)
          6'd0:    t = '{16'd659, 16'd90};
          6'd1:    t = '{16'd0,   16'd60};
          6'd2:    t = '{16'd659, 16'd90};
          6'd3:    t = '{16'd0,   16'd60};
          6'd4:    t = '{16'd523, 16'd180};
          6'd5:    t = '{16'd0,   16'd60};
          default: t = '0;
        endcase
      end
      2'd3: begin
        case (i)
          6'd0:    t = '{16'd740,  16'd120};
          6'd1:    t = '{16'd932,  16'd120};
          6'd2:    t = '{16'd1175, 16'd140};
          6'd3:    t = '{16'd1109, 16'd160};
          6'd4:    t = '{16'd0,    16'd80};
          default: t = '0;
        endcase
      end
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/mts_note_rom.sv
// Synchronous note ROM with a registered read.
`default_nettype none

module mts_note_rom #(
  parameter int IDX_W = 3
) (
  input  wire                  clk,
  input  wire                  rd_en,
  input  wire [1:0]            rd_melody,
  input  wire [IDX_W-1:0]      rd_index,
  output mts_pkg::note_t       rd_data
);
  import mts_pkg::*;

  mts_pkg::note_t data_q;

  // Read is registered and held until the next enabled read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_q <= rom_note(rd_melody, NOTE_IDX_W'(rd_index));
    end
  end

  assign rd_data = data_q;

endmodule

`default_nettype wire

// File: rtl/core/mts_duty_unit.sv
// Configuration registers and the duty value for sounding notes.
`default_nettype none

module mts_duty_unit (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire [mts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [mts_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [15:0]                   duty
);
  import mts_pkg::*;

  logic [4:0]             res_bits;
  logic [6:0]             duty_pct;
  logic [4:0]             res_clamped;
  logic [6:0]             pct_clamped;
  logic [15:0]            full_scale;
  logic [DUTY_PROD_W-1:0] prod_next;
  logic [DUTY_PROD_W-1:0] prod;
  logic [46:0]            recip_mul;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_bits <= RES_BITS_RESET;
      duty_pct <= DUTY_PCT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_RESOLUTION) begin
        res_bits <= cfg_data[4:0];
      end
      if (cfg_index == REG_DUTY_PCT) begin
        duty_pct <= cfg_data[6:0];
      end
    end
  end

  // Clamp both settings and form full scale times percent.
  always_comb begin
    res_clamped = (res_bits > RES_BITS_MAX) ? RES_BITS_MAX : res_bits;
    pct_clamped = (duty_pct > DUTY_PCT_MAX) ? DUTY_PCT_MAX : duty_pct;
    full_scale  = 16'((17'(1) << res_clamped) - 17'(1));
    prod_next   = DUTY_PROD_W'(full_scale) * DUTY_PROD_W'(pct_clamped);
  end

  // The product is registered so that the reciprocal multiply starts from a flop.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod <= DUTY_PROD_W'(1023 * 50);
    end else begin
      prod <= prod_next;
    end
  end

  // Divide by one hundred through the scaled reciprocal.
  assign recip_mul = 47'(prod) * 47'(DUTY_RECIP);
  assign duty      = recip_mul[DUTY_SHIFT +: 16];

endmodule

`default_nettype wire

// File: rtl/core/melody_tone_sequencer.sv
// Top level of the melody tone sequencer: note control, ROM, duty unit and result register.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------
//   request  | in_valid/in_ready  | in_data  (mode, direction)
//   result   | out_valid/out_ready| out_data (tone_freq, duty)
//   config   | cfg_we             | cfg_index, cfg_data
//
// One request is taken per cycle while in_ready is high; a request that yields a result
// passes through the registered note ROM read and ROM stage, then the result register.
// The countdown forwards the ROM duration to the next request, so ticks may follow
// a start or a note change in the very next cycle.
// Synchronous reset clears the play state, the pipeline and the result valid.
// A stalled result holds the ROM stage; requests are refused only when both are full.
`default_nettype none

module melody_tone_sequencer #(
  parameter int NUM_MELODIES = 4,
  parameter int MAX_NOTES    = 8
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  mts_pkg::mts_in_t              in_data,
  output logic                          out_valid,
  input  wire                           out_ready,
  output mts_pkg::mts_out_t             out_data,
  input  wire                           cfg_we,
  input  wire [mts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [mts_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mts_pkg::*;

  localparam int IDX_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

  typedef struct packed {
    logic valid;
    logic emit;
    logic note;
  } stage_t;

  // Play state.
  logic              active;
  logic              active_next;
  logic [1:0]        melody_sel;
  logic [1:0]        melody_sel_next;
  logic [IDX_W-1:0]  note_index;
  logic [IDX_W-1:0]  note_index_next;
  logic [15:0]       remaining_ms;

  stage_t            s1;
  stage_t            s1_next;
  logic              s1_adv;
  logic              out_free;
  logic              accept;

  logic              rd_en;
  logic [1:0]        rd_melody;
  logic [IDX_W-1:0]  rd_index;
  note_t             rom_q;
  logic [15:0]       duty_val;

  logic [15:0]       rem_eff;
  logic              tick_dec;
  logic [LEN_W-1:0]  len_dir;
  logic [LEN_W-1:0]  len_sel;
  logic [IDX_W:0]    idx_inc;

  mts_note_rom #(
    .IDX_W     (IDX_W)
  ) u_rom (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_melody (rd_melody),
    .rd_index  (rd_index),
    .rd_data   (rom_q)
  );

  mts_duty_unit u_duty (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .duty      (duty_val)
  );

  // Melody length, zero for melodies that are not present.
  function automatic logic [LEN_W-1:0] melody_len(input logic [1:0] m);
    logic [LEN_W-1:0] n;
    n = LEN_W'(rom_len(m));
    if (n > LEN_W'(MAX_NOTES)) begin
      n = LEN_W'(MAX_NOTES);
    end
    if (5'(m) >= 5'(NUM_MELODIES)) begin
      n = '0;
    end
    return n;
  endfunction

  // Handshake between the stages.
  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1.valid && (!s1.emit || out_free);
  assign in_ready = !s1.valid || s1_adv;
  assign accept   = in_valid && in_ready;

  // A note read in flight carries the countdown that the next request sees.
  assign rem_eff  = (s1.valid && s1.note) ? rom_q.dur : remaining_ms;
  assign len_dir  = melody_len(in_data.direction);
  assign len_sel  = melody_len(melody_sel);
  assign idx_inc  = (IDX_W + 1)'(note_index) + (IDX_W + 1)'(1);

  // Decode the request against the play state.
  always_comb begin
    active_next     = active;
    melody_sel_next = melody_sel;
    note_index_next = note_index;
    tick_dec        = 1'b0;
    rd_en           = 1'b0;
    rd_melody       = melody_sel;
    rd_index        = note_index;
    s1_next         = '0;
    if (accept) begin
      s1_next.valid = 1'b1;
      case (in_data.mode)
        MODE_START: begin
          s1_next.emit = 1'b1;
          if (len_dir == '0) begin
            active_next = 1'b0;
          end else begin
            active_next     = 1'b1;
            melody_sel_next = in_data.direction;
            note_index_next = '0;
            rd_en           = 1'b1;
            rd_melody       = in_data.direction;
            rd_index        = '0;
            s1_next.note    = 1'b1;
          end
        end
        MODE_TICK: begin
          if (active) begin
            if (rem_eff > 16'd1) begin
              tick_dec = 1'b1;
            end else if (len_sel == '0) begin
              active_next  = 1'b0;
              s1_next.emit = 1'b1;
            end else begin
              if (LEN_W'(idx_inc) >= len_sel) begin
                note_index_next = '0;
              end else begin
                note_index_next = IDX_W'(idx_inc);
              end
              rd_en        = 1'b1;
              rd_melody    = melody_sel;
              rd_index     = note_index_next;
              s1_next.emit = 1'b1;
              s1_next.note = 1'b1;
            end
          end
        end
        MODE_STOP: begin
          active_next  = 1'b0;
          s1_next.emit = 1'b1;
        end
        default: begin
          s1_next.valid = 1'b1;
        end
      endcase
    end
  end

  // Play state and countdown.
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      melody_sel   <= 2'd0;
      note_index   <= '0;
      remaining_ms <= 16'd0;
    end else begin
      active     <= active_next;
      melody_sel <= melody_sel_next;
      note_index <= note_index_next;
      if (tick_dec) begin
        remaining_ms <= rem_eff - 16'd1;
      end else if (s1.valid && s1.note && s1_adv) begin
        remaining_ms <= rom_q.dur;
      end
    end
  end

  // ROM stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (in_ready) begin
      s1 <= s1_next;
    end
  end

  // Result register; silent notes and rests carry zero duty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.emit) begin
      out_data.tone_freq <= s1.note ? rom_q.freq : 16'd0;
      out_data.duty      <= (s1.note && rom_q.freq != 16'd0) ? duty_val : 16'd0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mts_checker.sv
// Port-level checks on the melody tone sequencer and their binding.
`default_nettype none

module mts_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           out_valid,
  input wire                           out_ready,
  input mts_pkg::mts_out_t             out_data
);
  import mts_pkg::*;

  // A stalled result keeps its valid.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // Silence never carries duty.
  a_silent_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.tone_freq == 16'd0 |-> out_data.duty == 16'd0)
    else $error("silent result with nonzero duty");

endmodule

bind melody_tone_sequencer mts_checker u_mts_checker (.*);

`default_nettype wire
